>>> design/p2ba_pkg.sv
// p2ba_pkg: types, constants and codes of the power-of-two block allocator
// used by p2ba_ctrl, p2ba_dp and the top level; depends on nothing
`default_nettype none

package p2ba_pkg;

  localparam int HEAP_BYTES  = 262144;
  localparam int NUM_CLASSES = 14;
  localparam int UNITS       = HEAP_BYTES / 8;
  localparam int UNIT_W      = $clog2(UNITS);
  localparam int HEAD_W      = UNIT_W + 1;
  localparam int BRK_W       = $clog2(HEAP_BYTES) + 1;
  localparam int LIM_W       = BRK_W + 1;
  localparam int CLS_W       = $clog2(NUM_CLASSES + 1);
  localparam int ADDR_W      = 18;
  localparam int SIZE_W      = 16;
  localparam int HL_W        = 19;
  localparam int CNT_W       = 9;
  localparam int CLR_W       = UNIT_W;

  localparam logic [LIM_W-1:0]  POOL_BYTES     = LIM_W'(2048);
  localparam logic [LIM_W-1:0]  HEAP_LIM       = LIM_W'(HEAP_BYTES);
  localparam logic [HL_W-1:0]   HEAP_LIMIT_RST = HL_W'(262144);
  localparam logic [16:0]       SIZE_MAX       = 17'h0ffff;
  localparam logic [CLS_W-1:0]  SPLIT_CLASSES  = CLS_W'(8);
  localparam logic [CLS_W-1:0]  COPY_CAP_CLASS = CLS_W'(13);
  localparam logic [SIZE_W-1:0] COPY_CAP       = 16'd65528;
  localparam logic [2:0]        SEED_LAST      = 3'd7;
  // multiply by this and shift right by RECIP_SH divides by five
  localparam logic [15:0]       RECIP5         = 16'd52429;
  localparam int                RECIP_SH       = 18;

  typedef enum logic [1:0] {
    MARK_NONE  = 2'd0,
    MARK_FREE  = 2'd1,
    MARK_ALLOC = 2'd2
  } mark_e;

  typedef struct packed {
    mark_e              mark;
    logic [CLS_W-1:0]   cls;
    logic [SIZE_W-1:0]  size;
    logic [HEAD_W-1:0]  link;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OOM       = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_CORRUPT   = 3'd3,
    ST_NOT_ALLOC = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_CHK_OLD, S_R_DECIDE, S_A_START,
    S_SEED_GROW, S_SEED_PUSH, S_SEED_NEXT, S_WARN, S_GROW, S_SPLIT,
    S_A_CHECK, S_POP_RD, S_POP_WR, S_MOVE_PUSH, S_FREE_PUSH, S_DONE
  } state_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_LATCH, CMD_RD_OLD, CMD_CAPTURE, CMD_INPLACE,
    CMD_STATUS, CMD_SEED_GROW, CMD_SEED_PUSH, CMD_NEXT_POOL, CMD_SEEDED,
    CMD_WARN, CMD_GROW, CMD_SPLIT, CMD_POP_RD, CMD_POP_WR, CMD_FREE_PUSH,
    CMD_MOVE_PUSH, CMD_LOAD_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e    kind;
    status_e code;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic is_resize;
    logic addr_zero;
    logic addr_bad;
    logic too_large;
    logic cls_oob;
    logic head_empty;
    logic seeded;
    logic pool2;
    logic pool_fits;
    logic class_fits;
    logic seed_last;
    logic cnt_last;
    logic hdr_alloc_ok;
    logic inplace;
    logic pop_ok;
    logic clr_last;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> design/p2ba_ram.sv
// p2ba_ram: generic single-port-write, single-port-read RAM, registered read
// depends on nothing
`default_nettype none

module p2ba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/p2ba_ctrl.sv
// p2ba_ctrl: request sequencer of the allocator, drives datapath commands
// depends on p2ba_pkg
`default_nettype none

module p2ba_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire p2ba_pkg::dp_sts_t sts_i,
  output p2ba_pkg::cmd_t         cmd_o
);

  p2ba_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= p2ba_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o.kind  = p2ba_pkg::CMD_NONE;
    cmd_o.code  = p2ba_pkg::ST_OK;
    in_ready_o  = 1'b0;
    case (state_q)
      p2ba_pkg::S_CLEAR: begin
        cmd_o.kind = p2ba_pkg::CMD_CLEAR;
        if (sts_i.clr_last) state_d = p2ba_pkg::S_IDLE;
      end
      p2ba_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.kind = p2ba_pkg::CMD_LATCH;
          state_d    = p2ba_pkg::S_DECODE;
        end
      end
      p2ba_pkg::S_DECODE: begin
        if (sts_i.is_alloc) begin
          state_d = p2ba_pkg::S_A_START;
        end else if ((sts_i.is_free && !sts_i.addr_zero) || sts_i.is_resize) begin
          if (sts_i.addr_bad) begin
            cmd_o.kind = p2ba_pkg::CMD_STATUS;
            cmd_o.code = p2ba_pkg::ST_NOT_ALLOC;
            state_d    = p2ba_pkg::S_DONE;
          end else begin
            cmd_o.kind = p2ba_pkg::CMD_RD_OLD;
            state_d    = p2ba_pkg::S_CHK_OLD;
          end
        end else begin
          state_d = p2ba_pkg::S_DONE;
        end
      end
      p2ba_pkg::S_CHK_OLD: begin
        if (!sts_i.hdr_alloc_ok) begin
          cmd_o.kind = p2ba_pkg::CMD_STATUS;
          cmd_o.code = p2ba_pkg::ST_NOT_ALLOC;
          state_d    = p2ba_pkg::S_DONE;
        end else begin
          cmd_o.kind = p2ba_pkg::CMD_CAPTURE;
          state_d    = sts_i.is_free ? p2ba_pkg::S_FREE_PUSH : p2ba_pkg::S_R_DECIDE;
        end
      end
      p2ba_pkg::S_R_DECIDE: begin
        if (sts_i.inplace) begin
          cmd_o.kind = p2ba_pkg::CMD_INPLACE;
          state_d    = p2ba_pkg::S_DONE;
        end else begin
          state_d = p2ba_pkg::S_A_START;
        end
      end
      p2ba_pkg::S_A_START: begin
        if (sts_i.too_large) begin
          cmd_o.kind = p2ba_pkg::CMD_STATUS;
          cmd_o.code = p2ba_pkg::ST_TOO_LARGE;
          state_d    = p2ba_pkg::S_DONE;
        end else if (sts_i.cls_oob) begin
          cmd_o.kind = p2ba_pkg::CMD_STATUS;
          cmd_o.code = p2ba_pkg::ST_OOM;
          state_d    = p2ba_pkg::S_DONE;
        end else if (sts_i.head_empty) begin
          state_d = sts_i.seeded ? p2ba_pkg::S_WARN : p2ba_pkg::S_SEED_GROW;
        end else begin
          state_d = p2ba_pkg::S_POP_RD;
        end
      end
      p2ba_pkg::S_SEED_GROW: begin
        cmd_o.kind = p2ba_pkg::CMD_SEED_GROW;
        state_d    = sts_i.pool_fits ? p2ba_pkg::S_SEED_PUSH : p2ba_pkg::S_SEED_NEXT;
      end
      p2ba_pkg::S_SEED_PUSH: begin
        cmd_o.kind = p2ba_pkg::CMD_SEED_PUSH;
        if (sts_i.seed_last) state_d = p2ba_pkg::S_SEED_NEXT;
      end
      p2ba_pkg::S_SEED_NEXT: begin
        if (sts_i.pool2) begin
          cmd_o.kind = p2ba_pkg::CMD_SEEDED;
          state_d    = p2ba_pkg::S_WARN;
        end else begin
          cmd_o.kind = p2ba_pkg::CMD_NEXT_POOL;
          state_d    = p2ba_pkg::S_SEED_GROW;
        end
      end
      p2ba_pkg::S_WARN: begin
        cmd_o.kind = p2ba_pkg::CMD_WARN;
        state_d    = p2ba_pkg::S_GROW;
      end
      p2ba_pkg::S_GROW: begin
        cmd_o.kind = p2ba_pkg::CMD_GROW;
        state_d    = sts_i.class_fits ? p2ba_pkg::S_SPLIT : p2ba_pkg::S_A_CHECK;
      end
      p2ba_pkg::S_SPLIT: begin
        cmd_o.kind = p2ba_pkg::CMD_SPLIT;
        if (sts_i.cnt_last) state_d = p2ba_pkg::S_A_CHECK;
      end
      p2ba_pkg::S_A_CHECK: begin
        if (sts_i.head_empty) begin
          cmd_o.kind = p2ba_pkg::CMD_STATUS;
          cmd_o.code = p2ba_pkg::ST_OOM;
          state_d    = p2ba_pkg::S_DONE;
        end else begin
          state_d = p2ba_pkg::S_POP_RD;
        end
      end
      p2ba_pkg::S_POP_RD: begin
        cmd_o.kind = p2ba_pkg::CMD_POP_RD;
        state_d    = p2ba_pkg::S_POP_WR;
      end
      p2ba_pkg::S_POP_WR: begin
        cmd_o.kind = p2ba_pkg::CMD_POP_WR;
        state_d    = (sts_i.pop_ok && sts_i.is_resize) ? p2ba_pkg::S_MOVE_PUSH
                                                       : p2ba_pkg::S_DONE;
      end
      p2ba_pkg::S_MOVE_PUSH: begin
        cmd_o.kind = p2ba_pkg::CMD_MOVE_PUSH;
        state_d    = p2ba_pkg::S_DONE;
      end
      p2ba_pkg::S_FREE_PUSH: begin
        cmd_o.kind = p2ba_pkg::CMD_FREE_PUSH;
        state_d    = p2ba_pkg::S_DONE;
      end
      p2ba_pkg::S_DONE: begin
        // wait for the output register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.kind  = p2ba_pkg::CMD_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = p2ba_pkg::S_IDLE;
        end
      end
      default: state_d = p2ba_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> design/p2ba_dp.sv
// p2ba_dp: allocator datapath: list heads, break, warning, header store
// depends on p2ba_pkg and p2ba_ram
`default_nettype none

module p2ba_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire p2ba_pkg::cmd_t                cmd_i,
  output p2ba_pkg::dp_sts_t                  sts_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [p2ba_pkg::SIZE_W-1:0]   req_bytes_i,
  input  wire logic [p2ba_pkg::ADDR_W-1:0]   block_addr_i,
  input  wire logic                          heap_limit_we_i,
  input  wire logic [p2ba_pkg::HL_W-1:0]     heap_limit_i,
  output logic [2:0]                         status_o,
  output logic [p2ba_pkg::ADDR_W-1:0]        result_addr_o,
  output logic                               moved_o,
  output logic [p2ba_pkg::SIZE_W-1:0]        copy_bytes_o,
  output logic [1:0]                         warn_level_o,
  output logic                               warn_raised_o
);

  localparam int UW = p2ba_pkg::UNIT_W;
  localparam int HW = p2ba_pkg::HEAD_W;
  localparam int BW = p2ba_pkg::BRK_W;
  localparam int LW = p2ba_pkg::LIM_W;
  localparam int CW = p2ba_pkg::CLS_W;
  localparam int AW = p2ba_pkg::ADDR_W;
  localparam int SW = p2ba_pkg::SIZE_W;
  localparam int RECIP_SH_TOP = p2ba_pkg::RECIP_SH + 14;

  // request and control registers
  p2ba_pkg::op_e     op_q;
  logic [SW-1:0]     n_q;
  logic [AW-1:0]     addr_q;
  logic [HW-1:0]     heads_q [p2ba_pkg::NUM_CLASSES];
  logic [BW-1:0]     brk_q, at_q;
  logic              seeded_q, pool2_q, raised_q;
  logic [1:0]        warn_q;
  logic [p2ba_pkg::HL_W-1:0] heap_limit_q;
  logic [14:0]       q20_q;
  logic [p2ba_pkg::CNT_W-1:0] cnt_q;
  logic [p2ba_pkg::CLR_W-1:0] clr_q;
  logic [UW-1:0]     unit_q, old_unit_q;
  logic [CW-1:0]     old_cls_q;
  logic [SW-1:0]     old_size_q;
  logic [HW-1:0]     old_link_q;
  p2ba_pkg::status_e status_q, out_status_q;
  logic [AW-1:0]     result_q, out_result_q;
  logic              moved_q, out_moved_q;
  logic [SW-1:0]     copy_q, out_copy_q;
  logic [1:0]        out_warn_q;
  logic              out_raised_q;

  // header store port
  logic                 we;
  logic [UW-1:0]        waddr, raddr;
  p2ba_pkg::hdr_t       wdata, rd;
  logic [p2ba_pkg::HDR_W-1:0] rdata;

  // combinational helpers
  logic [16:0]   nbytes;
  logic [14:0]   s_val;
  logic [CW-1:0] k, k_idx;
  logic [LW-1:0] nb20, lim, brk20, ref_bytes, step, seed_adv, thr;
  logic [HW-1:0] head_k;
  logic [p2ba_pkg::CNT_W-1:0] count_m1;
  logic [2:0]    seed_cls;
  logic [UW-1:0] addr_unit, at_unit;
  logic [16:0]   q4;
  logic [32:0]   prod;
  logic [SW-1:0] tocopy_cap, tocopy;
  logic [HW-1:0] split_link;

  always_comb begin
    nbytes = ({1'b0, n_q} + 17'd15) & ~17'd7;
    s_val  = 15'((nbytes - 17'd1) >> 2);
    k      = '0;
    for (int i = 0; i < 15; i++) begin
      if (s_val[i]) k = CW'(i);
    end
    k_idx  = (k < CW'(p2ba_pkg::NUM_CLASSES)) ? k : '0;
    head_k = heads_q[k_idx];
    nb20   = LW'(nbytes);
    lim    = (LW'(heap_limit_q) < p2ba_pkg::HEAP_LIM) ? LW'(heap_limit_q)
                                                    : p2ba_pkg::HEAP_LIM;
    brk20  = LW'(brk_q);
    step   = LW'(8) << k;
    ref_bytes = (k < p2ba_pkg::SPLIT_CLASSES) ? p2ba_pkg::POOL_BYTES : step;
    count_m1  = (k < p2ba_pkg::SPLIT_CLASSES)
              ? (p2ba_pkg::CNT_W'(256) >> k) - p2ba_pkg::CNT_W'(1) : '0;
    // seeded pool: a spare class-0 block, then one block of classes 0..6
    seed_cls  = (cnt_q == '0) ? 3'd0 : 3'(cnt_q - 1'b1);
    seed_adv  = (cnt_q == '0) ? LW'(8) : (LW'(8) << seed_cls);
    addr_unit = UW'(addr_q[AW-1:3] - 1'b1);
    at_unit   = at_q[UW+2:3];
    split_link = (cnt_q == count_m1) ? '0
               : HW'(HW'((at_q + BW'(step)) >> 3) + 1'b1);
    q4   = heap_limit_q[p2ba_pkg::HL_W-1:2];
    prod = 33'(q4) * 33'(p2ba_pkg::RECIP5);
    case (warn_q)
      2'd0:    thr = LW'(q4) * LW'(3);
      2'd1:    thr = LW'(q20_q) * LW'(17);
      default: thr = LW'(q20_q) * LW'(19);
    endcase
    tocopy_cap = (old_cls_q >= p2ba_pkg::COPY_CAP_CLASS) ? p2ba_pkg::COPY_CAP
                                                         : old_size_q;
    tocopy     = (n_q < tocopy_cap) ? n_q : tocopy_cap;
    rd = p2ba_pkg::hdr_t'(rdata);
  end

  always_comb begin
    sts_o.is_alloc   = (op_q == p2ba_pkg::OP_ALLOC) ||
                       (op_q == p2ba_pkg::OP_RESIZE && addr_q == '0);
    sts_o.is_free    = (op_q == p2ba_pkg::OP_FREE);
    sts_o.is_resize  = (op_q == p2ba_pkg::OP_RESIZE) && (addr_q != '0);
    sts_o.addr_zero  = (addr_q == '0);
    sts_o.addr_bad   = (addr_q < AW'(8)) || (addr_q[2:0] != 3'd0) ||
                       (LW'(addr_q) >= p2ba_pkg::HEAP_LIM);
    sts_o.too_large  = (nbytes > p2ba_pkg::SIZE_MAX);
    sts_o.cls_oob    = (k >= CW'(p2ba_pkg::NUM_CLASSES));
    sts_o.head_empty = (head_k == '0);
    sts_o.seeded     = seeded_q;
    sts_o.pool2      = pool2_q;
    sts_o.pool_fits  = (brk20 + p2ba_pkg::POOL_BYTES) <= lim;
    sts_o.class_fits = (brk20 + ref_bytes) <= lim;
    sts_o.seed_last  = (cnt_q[2:0] == p2ba_pkg::SEED_LAST);
    sts_o.cnt_last   = (cnt_q == count_m1);
    sts_o.hdr_alloc_ok = (rd.mark == p2ba_pkg::MARK_ALLOC) &&
                         (rd.cls < CW'(p2ba_pkg::NUM_CLASSES));
    sts_o.inplace    = (nb20 > (LW'(4) << old_cls_q)) && (nb20 <= (LW'(8) << old_cls_q));
    sts_o.pop_ok     = (rd.mark == p2ba_pkg::MARK_FREE) && (rd.cls == k);
    sts_o.clr_last   = (clr_q == '1);
  end

  // header store access per command
  always_comb begin
    we    = 1'b0;
    waddr = old_unit_q;
    wdata = '0;
    raddr = addr_unit;
    case (cmd_i.kind)
      p2ba_pkg::CMD_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
      end
      p2ba_pkg::CMD_INPLACE: begin
        we    = 1'b1;
        wdata = '{p2ba_pkg::MARK_ALLOC, old_cls_q, n_q, old_link_q};
      end
      p2ba_pkg::CMD_SEED_PUSH: begin
        we    = 1'b1;
        waddr = at_unit;
        wdata = '{p2ba_pkg::MARK_FREE, CW'(seed_cls), '0, heads_q[CW'(seed_cls)]};
      end
      p2ba_pkg::CMD_SPLIT: begin
        we    = 1'b1;
        waddr = at_unit;
        wdata = '{p2ba_pkg::MARK_FREE, k, '0, split_link};
      end
      p2ba_pkg::CMD_POP_RD: raddr = UW'(head_k - 1'b1);
      p2ba_pkg::CMD_POP_WR: begin
        we    = sts_o.pop_ok;
        waddr = unit_q;
        wdata = '{p2ba_pkg::MARK_ALLOC, k, n_q, rd.link};
      end
      p2ba_pkg::CMD_FREE_PUSH, p2ba_pkg::CMD_MOVE_PUSH: begin
        we    = 1'b1;
        wdata = '{p2ba_pkg::MARK_FREE, old_cls_q, old_size_q, heads_q[old_cls_q]};
      end
      default: we = 1'b0;
    endcase
  end

  p2ba_ram #(
    .WIDTH (p2ba_pkg::HDR_W),
    .DEPTH (p2ba_pkg::UNITS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < p2ba_pkg::NUM_CLASSES; i++) heads_q[i] <= '0;
      brk_q        <= '0;
      seeded_q     <= 1'b0;
      pool2_q      <= 1'b0;
      warn_q       <= '0;
      raised_q     <= 1'b0;
      heap_limit_q <= p2ba_pkg::HEAP_LIMIT_RST;
      clr_q        <= '0;
    end else begin
      if (heap_limit_we_i) heap_limit_q <= heap_limit_i;
      case (cmd_i.kind)
        p2ba_pkg::CMD_CLEAR: clr_q <= clr_q + 1'b1;
        p2ba_pkg::CMD_LATCH: begin
          raised_q <= 1'b0;
          pool2_q  <= 1'b0;
        end
        p2ba_pkg::CMD_SEED_GROW: begin
          if (sts_o.pool_fits) brk_q <= BW'(brk20 + p2ba_pkg::POOL_BYTES);
        end
        p2ba_pkg::CMD_SEED_PUSH: heads_q[CW'(seed_cls)] <= HW'(at_unit) + 1'b1;
        p2ba_pkg::CMD_NEXT_POOL: pool2_q  <= 1'b1;
        p2ba_pkg::CMD_SEEDED:    seeded_q <= 1'b1;
        p2ba_pkg::CMD_WARN: begin
          if (warn_q != 2'd3 && brk20 > thr) begin
            warn_q   <= warn_q + 1'b1;
            raised_q <= 1'b1;
          end
        end
        p2ba_pkg::CMD_GROW: begin
          if (sts_o.class_fits) begin
            brk_q          <= BW'(brk20 + ref_bytes);
            heads_q[k_idx] <= HW'(brk_q >> 3) + 1'b1;
          end
        end
        p2ba_pkg::CMD_POP_WR: heads_q[k_idx] <= rd.link;
        p2ba_pkg::CMD_FREE_PUSH, p2ba_pkg::CMD_MOVE_PUSH:
          heads_q[old_cls_q] <= HW'(old_unit_q) + 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    q20_q <= prod[RECIP_SH_TOP:p2ba_pkg::RECIP_SH];
    case (cmd_i.kind)
      p2ba_pkg::CMD_LATCH: begin
        op_q     <= p2ba_pkg::op_e'(op_i);
        n_q      <= req_bytes_i;
        addr_q   <= block_addr_i;
        status_q <= p2ba_pkg::ST_OK;
        result_q <= '0;
        moved_q  <= 1'b0;
        copy_q   <= '0;
      end
      p2ba_pkg::CMD_CAPTURE: begin
        old_unit_q <= addr_unit;
        old_cls_q  <= rd.cls;
        old_size_q <= rd.size;
        old_link_q <= rd.link;
      end
      p2ba_pkg::CMD_INPLACE: result_q <= addr_q;
      p2ba_pkg::CMD_STATUS:  status_q <= cmd_i.code;
      p2ba_pkg::CMD_SEED_GROW: begin
        at_q  <= brk_q;
        cnt_q <= '0;
      end
      p2ba_pkg::CMD_SEED_PUSH: begin
        at_q  <= BW'(LW'(at_q) + seed_adv);
        cnt_q <= cnt_q + 1'b1;
      end
      p2ba_pkg::CMD_GROW: begin
        at_q  <= brk_q;
        cnt_q <= '0;
      end
      p2ba_pkg::CMD_SPLIT: begin
        at_q  <= BW'(LW'(at_q) + step);
        cnt_q <= cnt_q + 1'b1;
      end
      p2ba_pkg::CMD_POP_RD: unit_q <= UW'(head_k - 1'b1);
      p2ba_pkg::CMD_POP_WR: begin
        if (sts_o.pop_ok) result_q <= AW'({unit_q, 3'b000}) + AW'(8);
        else              status_q <= p2ba_pkg::ST_CORRUPT;
      end
      p2ba_pkg::CMD_MOVE_PUSH: begin
        moved_q <= 1'b1;
        copy_q  <= tocopy;
      end
      p2ba_pkg::CMD_LOAD_OUT: begin
        out_status_q <= status_q;
        out_result_q <= result_q;
        out_moved_q  <= moved_q;
        out_copy_q   <= copy_q;
        out_warn_q   <= warn_q;
        out_raised_q <= raised_q;
      end
      default: ;
    endcase
  end

  assign status_o      = 3'(out_status_q);
  assign result_addr_o = out_result_q;
  assign moved_o       = out_moved_q;
  assign copy_bytes_o  = out_copy_q;
  assign warn_level_o  = out_warn_q;
  assign warn_raised_o = out_raised_q;

endmodule

`default_nettype wire

>>> design/power_of_two_block_allocator.sv
// power_of_two_block_allocator: top level, sequencer plus datapath
// depends on p2ba_pkg, p2ba_ctrl, p2ba_dp (and p2ba_ram below it)
//
//  channel   handshake                  payload
//  input     in_valid_i / in_ready_o    op_i, req_bytes_i, block_addr_i
//  output    out_valid_o / out_ready_i  status_o, result_addr_o, moved_o,
//                                       copy_bytes_o, warn_level_o, warn_raised_o
//  config    heap_limit_we_i            heap_limit_i
//
// one request at a time; a list pop, a free and an in-place resize each read
// a header and then write one, all through the single header store port
// a refill carves up to 256 blocks from the grown area; the first
// refill also sets up the two seed pools
// after reset the header store is swept clear, all 32768 entries, with no request taken
// a new request is taken while the previous result still waits on the output

`default_nettype none

module power_of_two_block_allocator (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [15:0]                 req_bytes_i,
  input  wire logic [17:0]                 block_addr_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       status_o,
  output logic [17:0]                      result_addr_o,
  output logic                             moved_o,
  output logic [15:0]                      copy_bytes_o,
  output logic [1:0]                       warn_level_o,
  output logic                             warn_raised_o,
  input  wire logic                        heap_limit_we_i,
  input  wire logic [18:0]                 heap_limit_i
);

  p2ba_pkg::cmd_t    cmd;
  p2ba_pkg::dp_sts_t sts;

  p2ba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  p2ba_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .req_bytes_i     (req_bytes_i),
    .block_addr_i    (block_addr_i),
    .heap_limit_we_i (heap_limit_we_i),
    .heap_limit_i    (heap_limit_i),
    .status_o        (status_o),
    .result_addr_o   (result_addr_o),
    .moved_o         (moved_o),
    .copy_bytes_o    (copy_bytes_o),
    .warn_level_o    (warn_level_o),
    .warn_raised_o   (warn_raised_o)
  );

endmodule

`default_nettype wire
